// ----- rtl/vtg_pkg.sv -----
`default_nettype none

package vtg_pkg;

    // Coordinate width: points and deltas wrap at this width and are
    // sign-extended into the 32-bit fields (legal range 16..32).
    localparam int unsigned COORD_BITS = 32;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned OP_BITS    = 3;
    localparam int unsigned CNT_BITS   = WORD_BITS - OP_BITS;
    localparam int unsigned WRAP_SH    = WORD_BITS - COORD_BITS;

    localparam logic [OP_BITS-1:0] OP_MOVE  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_LINE  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_CLOSE = 3'h7;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_DX  = 2'd1,
        PH_DY  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [OP_BITS-1:0]          command_code;
        logic signed [WORD_BITS-1:0] point_x;
        logic signed [WORD_BITS-1:0] point_y;
        logic signed [WORD_BITS-1:0] delta_x;
        logic signed [WORD_BITS-1:0] delta_y;
        logic [CNT_BITS-1:0]         extra_repeats;
        logic                        status;
        logic                        feature_end;
    } t_result;

    // Keep the low COORD_BITS bits and sign-extend them to a full word.
    function automatic logic [WORD_BITS-1:0] wrap_coord(input logic [WORD_BITS-1:0] v);
        logic signed [WORD_BITS-1:0] t;
        t = v << WRAP_SH;
        return t >>> WRAP_SH;
    endfunction

    function automatic logic [WORD_BITS-1:0] unzig(input logic [WORD_BITS-1:0] w);
        return wrap_coord((w >> 1) ^ {WORD_BITS{w[0]}});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vtg_word_if.sv -----
`default_nettype none

interface vtg_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] geometry_word;
    logic        last_word;

    modport source (output valid, output geometry_word, output last_word, input ready);
    modport sink   (input valid, input geometry_word, input last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/vtg_result_if.sv -----
`default_nettype none

interface vtg_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command_code;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic [28:0]        extra_repeats;
    logic               status;
    logic               feature_end;

    modport source (
        output valid, output command_code, output point_x, output point_y,
        output delta_x, output delta_y, output extra_repeats, output status,
        output feature_end, input ready
    );
    modport sink (
        input valid, input command_code, input point_x, input point_y,
        input delta_x, input delta_y, input extra_repeats, input status,
        input feature_end, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/vtg_decode_core.sv -----
`default_nettype none

module vtg_decode_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic [vtg_pkg::WORD_BITS-1:0]  i_word,
    input  wire logic                           i_last,
    output logic                                o_emit,
    output vtg_pkg::t_result                    o_res
);
    import vtg_pkg::*;

    t_phase               r_phase, n_phase;
    logic [OP_BITS-1:0]   r_op, n_op;
    logic [CNT_BITS-1:0]  r_rep, n_rep;
    logic [WORD_BITS-1:0] r_held_dx, n_held_dx;
    logic [WORD_BITS-1:0] r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [WORD_BITS-1:0] r_rs_x, n_rs_x, r_rs_y, n_rs_y;
    logic [WORD_BITS-1:0] r_lp_x, n_lp_x, r_lp_y, n_lp_y;
    logic [WORD_BITS-1:0] r_ld_x, n_ld_x, r_ld_y, n_ld_y;

    logic [WORD_BITS-1:0] unz;
    logic [CNT_BITS-1:0]  cnt, eff;
    logic [OP_BITS-1:0]   op;
    logic                 emit;
    logic [WORD_BITS-1:0] px, py, dx, dy;
    logic [CNT_BITS-1:0]  extra;

    assign unz = unzig(i_word);
    assign cnt = i_word[WORD_BITS-1:OP_BITS];
    assign eff = (cnt == '0) ? CNT_BITS'(1) : cnt;
    assign op  = i_word[OP_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD;
            r_op      <= '0;
            r_rep     <= '0;
            r_held_dx <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_rs_x    <= '0;
            r_rs_y    <= '0;
            r_lp_x    <= '0;
            r_lp_y    <= '0;
            r_ld_x    <= '0;
            r_ld_y    <= '0;
        end else if (i_step) begin
            r_phase   <= i_last ? PH_CMD : n_phase;
            r_op      <= i_last ? '0 : n_op;
            r_rep     <= i_last ? '0 : n_rep;
            r_held_dx <= i_last ? '0 : n_held_dx;
            r_cur_x   <= i_last ? '0 : n_cur_x;
            r_cur_y   <= i_last ? '0 : n_cur_y;
            r_rs_x    <= i_last ? '0 : n_rs_x;
            r_rs_y    <= i_last ? '0 : n_rs_y;
            r_lp_x    <= i_last ? '0 : n_lp_x;
            r_lp_y    <= i_last ? '0 : n_lp_y;
            r_ld_x    <= i_last ? '0 : n_ld_x;
            r_ld_y    <= i_last ? '0 : n_ld_y;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_rep     = r_rep;
        n_held_dx = r_held_dx;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_rs_x    = r_rs_x;
        n_rs_y    = r_rs_y;
        n_lp_x    = r_lp_x;
        n_lp_y    = r_lp_y;
        n_ld_x    = r_ld_x;
        n_ld_y    = r_ld_y;
        emit      = 1'b0;
        px        = '0;
        py        = '0;
        dx        = '0;
        dy        = '0;
        extra     = '0;

        case (r_phase)
            PH_DX: begin
                n_held_dx = unz;
                n_phase   = PH_DY;
            end
            PH_DY: begin
                dx      = r_held_dx;
                dy      = unz;
                n_cur_x = wrap_coord(r_cur_x + dx);
                n_cur_y = wrap_coord(r_cur_y + dy);
                px      = n_cur_x;
                py      = n_cur_y;
                n_lp_x  = n_cur_x;
                n_lp_y  = n_cur_y;
                n_ld_x  = dx;
                n_ld_y  = dy;
                if (r_op == OP_MOVE) begin
                    n_rs_x = n_cur_x;
                    n_rs_y = n_cur_y;
                end
                emit    = 1'b1;
                n_rep   = r_rep - CNT_BITS'(1);
                n_phase = (n_rep != '0) ? PH_DX : PH_CMD;
            end
            default: begin
                // Command word; an unused phase code decodes the same way.
                n_op    = op;
                n_phase = PH_CMD;
                if (op == OP_MOVE || op == OP_LINE) begin
                    n_rep   = eff;
                    n_phase = PH_DX;
                end else if (op == OP_CLOSE) begin
                    dx     = wrap_coord(r_rs_x - r_lp_x);
                    dy     = wrap_coord(r_rs_y - r_lp_y);
                    px     = r_rs_x;
                    py     = r_rs_y;
                    n_lp_x = r_rs_x;
                    n_lp_y = r_rs_y;
                    n_ld_x = (eff > CNT_BITS'(1)) ? '0 : dx;
                    n_ld_y = (eff > CNT_BITS'(1)) ? '0 : dy;
                    extra  = eff - CNT_BITS'(1);
                    emit   = 1'b1;
                end else begin
                    px    = r_lp_x;
                    py    = r_lp_y;
                    dx    = r_ld_x;
                    dy    = r_ld_y;
                    extra = eff - CNT_BITS'(1);
                    emit  = 1'b1;
                end
            end
        endcase
    end

    assign o_emit = emit || i_last;

    always_comb begin
        o_res.command_code  = n_op;
        o_res.point_x       = px;
        o_res.point_y       = py;
        o_res.delta_x       = dx;
        o_res.delta_y       = dy;
        o_res.extra_repeats = extra;
        o_res.status        = (i_last && n_phase != PH_CMD) ? STATUS_TRUNCATED : STATUS_OK;
        o_res.feature_end   = i_last;
    end

endmodule

`default_nettype wire

// ----- rtl/vtg_out_buf.sv -----
`default_nettype none

module vtg_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire vtg_pkg::t_result i_data,
    output logic                  o_ready,
    vtg_result_if.source          o_res
);
    import vtg_pkg::*;

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    pop;

    assign pop     = r_main_valid && o_res.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            // Refill from the skid stage first; no push lands while it is full.
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push && !r_main_valid) begin
            r_main <= i_data;
        end
        if (!pop && i_push && r_main_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_res.valid         = r_main_valid;
    assign o_res.command_code  = r_main.command_code;
    assign o_res.point_x       = r_main.point_x;
    assign o_res.point_y       = r_main.point_y;
    assign o_res.delta_x       = r_main.delta_x;
    assign o_res.delta_y       = r_main.delta_y;
    assign o_res.extra_repeats = r_main.extra_repeats;
    assign o_res.status        = r_main.status;
    assign o_res.feature_end   = r_main.feature_end;

endmodule

`default_nettype wire

// ----- rtl/vector_tile_geometry_decoder.sv -----
// Vector tile geometry decoder: takes one 32-bit geometry word per beat on
// i_word (last_word marks the final word of a feature) and returns at most one
// result beat per word on o_res. A word is taken every cycle while the output
// stage has room; a result reaches o_res from the output register. The decode
// state (cursor, ring start, last point and delta) lives in one register set
// updated by per-axis 32-bit adds, and a two-entry output stage lets one more
// word be taken while a result is held by a stalled sink. MoveTo and LineTo
// commands, and the first word of each parameter pair, give no result unless
// they carry last_word; all state returns to reset after the last word.
`default_nettype none

module vector_tile_geometry_decoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    vtg_word_if.sink     i_word,
    vtg_result_if.source o_res
);
    import vtg_pkg::*;

    logic    step, emit, buf_ready;
    t_result res;

    assign i_word.ready = buf_ready;
    assign step         = i_word.valid && buf_ready;

    vtg_decode_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (i_word.geometry_word),
        .i_last  (i_word.last_word),
        .o_emit  (emit),
        .o_res   (res)
    );

    vtg_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step && emit),
        .i_data  (res),
        .o_ready (buf_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ----- rtl/vtg_checker.sv -----
`default_nettype none

module vtg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_last,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_point_x
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_point_x))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("last word beat produced no result");

endmodule

bind vector_tile_geometry_decoder vtg_checker u_vtg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_word.valid),
    .i_in_ready    (i_word.ready),
    .i_in_last     (i_word.last_word),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_point_x (o_res.point_x)
);

`default_nettype wire
